@@ hdl/pslw_pkg.sv @@
// ----------------------------------------------------------------------------
// pslw_pkg
// Types and constants for the PWM slew limiter with command watchdog.
// ----------------------------------------------------------------------------
package pslw_pkg;

   // Duty and time widths
   localparam int unsigned DUTY_W = 8;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DUTY_W-1:0] DUTY_FULL = 8'hFF;
   localparam logic [DUTY_W-1:0] DUTY_OFF = 8'h00;

   // Configuration register reset values
   localparam logic [TIME_W-1:0] TTL_RESET = 32'd10000;
   localparam logic [DUTY_W-1:0] STEP_RESET = 8'd4;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMMAND_TTL_MS = 3'd0,
      CSR_RAMP_STEP = 3'd1,
      CSR_FAN_A_PRESENT = 3'd2,
      CSR_FAN_B_PRESENT = 3'd3,
      CSR_PELTIER_ACTIVE_HIGH = 3'd4
   } csr_index_type;

   // Item kinds
   typedef enum logic {
      ACTION_TICK = 1'b0,
      ACTION_COMMAND = 1'b1
   } action_type;

   // Input beat
   typedef struct packed {
      logic action;
      logic [TIME_W-1:0] now_ms;
      logic [DUTY_W-1:0] fan_a_target;
      logic [DUTY_W-1:0] fan_b_target;
      logic [DUTY_W-1:0] peltier_a_target;
      logic [DUTY_W-1:0] peltier_b_target;
   } req_type;

   // Result beat
   typedef struct packed {
      logic [DUTY_W-1:0] fan_a_level;
      logic [DUTY_W-1:0] fan_b_level;
      logic [DUTY_W-1:0] peltier_a_level;
      logic [DUTY_W-1:0] peltier_b_level;
      logic [DUTY_W-1:0] peltier_a_drive;
      logic [DUTY_W-1:0] peltier_b_drive;
      logic [DUTY_W-1:0] peltier_fan_a_drive;
      logic [DUTY_W-1:0] peltier_fan_b_drive;
      logic command_stale;
   } rsp_type;

endpackage

@@ hdl/pwm_slew_limiter_with_watchdog.sv @@
// ----------------------------------------------------------------------------
// pwm_slew_limiter_with_watchdog
// Two ramped fan channels and two Peltier channels with a command timeout.
// ----------------------------------------------------------------------------
// A result beat is registered, into the skid entry if a stalled beat holds the result register.
// Throughput: one beat per cycle while req_stall is low; the whole update is one
// combinational pass from the state registers into the result register.
// A two-entry output (result register plus skid register) keeps input flowing
// while the consumer stalls; req_stall rises only when the skid entry is full.
// Reset (synchronous, active high) clears all levels, goals and the command
// time and loads the configuration defaults.
module pwm_slew_limiter_with_watchdog (
   input  logic                                  clock,
   input  logic                                  reset,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pslw_pkg::req_type                     req_data,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pslw_pkg::rsp_type                     rsp_data,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pslw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pslw_pkg::TIME_W-1:0]           csr_wdata
);

   localparam int unsigned DW = pslw_pkg::DUTY_W;
   localparam int unsigned TW = pslw_pkg::TIME_W;

   // Slew one level toward its goal by at most step
   function automatic logic [DW-1:0] slew(input logic [DW-1:0] cur,
                                          input logic [DW-1:0] goal,
                                          input logic [DW-1:0] step);
      logic [DW:0]   sum;
      logic [DW-1:0] diff;
      logic [DW-1:0] res;
      sum = {1'b0, cur} + {1'b0, step};
      diff = cur - goal;
      if (cur < goal) begin
         res = (sum > {1'b0, goal}) ? goal : sum[DW-1:0];
      end else if (cur > goal) begin
         res = (diff < step) ? goal : cur - step;
      end else begin
         res = cur;
      end
      return res;
   endfunction

   // Polarity applied to a Peltier pin
   function automatic logic [DW-1:0] polar(input logic act_high,
                                           input logic [DW-1:0] v);
      return act_high ? v : ~v;
   endfunction

   // Configuration registers
   logic [TW-1:0] ttl_ff;
   logic [DW-1:0] step_ff;
   logic          fan_a_pres_ff;
   logic          fan_b_pres_ff;
   logic          pelt_high_ff;

   // Channel state
   logic [DW-1:0] fan_a_cur_ff, fan_a_cur_in;
   logic [DW-1:0] fan_b_cur_ff, fan_b_cur_in;
   logic [DW-1:0] fan_a_goal_ff, fan_a_goal_in;
   logic [DW-1:0] fan_b_goal_ff, fan_b_goal_in;
   logic [DW-1:0] pelt_a_goal_ff, pelt_a_goal_in;
   logic [DW-1:0] pelt_b_goal_ff, pelt_b_goal_in;
   logic [DW-1:0] pelt_a_cur_ff, pelt_a_cur_in;
   logic [DW-1:0] pelt_b_cur_ff, pelt_b_cur_in;
   logic [TW-1:0] last_cmd_ff, last_cmd_in;

   // Output stage
   logic               out_valid_ff, out_valid_in;
   pslw_pkg::rsp_type  out_data_ff, out_data_in;
   logic               skid_valid_ff, skid_valid_in;
   pslw_pkg::rsp_type  skid_data_ff, skid_data_in;

   logic              req_accept;
   logic              out_pop;
   logic              is_cmd;
   logic [TW-1:0]     age;
   logic              stale;
   pslw_pkg::rsp_type result;

   assign req_stall = skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign out_pop = out_valid_ff && !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data = out_data_ff;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff <= pslw_pkg::TTL_RESET;
         step_ff <= pslw_pkg::STEP_RESET;
         fan_a_pres_ff <= 1'b1;
         fan_b_pres_ff <= 1'b1;
         pelt_high_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (pslw_pkg::csr_index_type'(csr_index))
            pslw_pkg::CSR_COMMAND_TTL_MS: ttl_ff <= csr_wdata;
            pslw_pkg::CSR_RAMP_STEP: step_ff <= csr_wdata[DW-1:0];
            pslw_pkg::CSR_FAN_A_PRESENT: fan_a_pres_ff <= csr_wdata[0];
            pslw_pkg::CSR_FAN_B_PRESENT: fan_b_pres_ff <= csr_wdata[0];
            pslw_pkg::CSR_PELTIER_ACTIVE_HIGH: pelt_high_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Watchdog: wrapped age against the timeout, ticks only
   assign is_cmd = (req_data.action == pslw_pkg::ACTION_COMMAND);
   assign age = req_data.now_ms - last_cmd_ff;
   assign stale = !is_cmd && (age > ttl_ff);

   // Next state for one accepted beat
   always_comb begin
      fan_a_cur_in = fan_a_cur_ff;
      fan_b_cur_in = fan_b_cur_ff;
      fan_a_goal_in = fan_a_goal_ff;
      fan_b_goal_in = fan_b_goal_ff;
      pelt_a_goal_in = pelt_a_goal_ff;
      pelt_b_goal_in = pelt_b_goal_ff;
      pelt_a_cur_in = pelt_a_cur_ff;
      pelt_b_cur_in = pelt_b_cur_ff;
      last_cmd_in = last_cmd_ff;
      if (is_cmd) begin
         fan_a_goal_in = req_data.fan_a_target;
         fan_b_goal_in = req_data.fan_b_target;
         pelt_a_goal_in = req_data.peltier_a_target;
         pelt_b_goal_in = req_data.peltier_b_target;
         last_cmd_in = req_data.now_ms;
      end else begin
         if (stale) begin
            fan_a_goal_in = pslw_pkg::DUTY_OFF;
            fan_b_goal_in = pslw_pkg::DUTY_OFF;
            pelt_a_goal_in = pslw_pkg::DUTY_OFF;
            pelt_b_goal_in = pslw_pkg::DUTY_OFF;
         end
         fan_a_cur_in = fan_a_pres_ff ? slew(fan_a_cur_ff, fan_a_goal_in, step_ff)
                                      : pslw_pkg::DUTY_OFF;
         fan_b_cur_in = fan_b_pres_ff ? slew(fan_b_cur_ff, fan_b_goal_in, step_ff)
                                      : pslw_pkg::DUTY_OFF;
         pelt_a_cur_in = pelt_a_goal_in;
         pelt_b_cur_in = pelt_b_goal_in;
      end
   end

   // Result beat built from the new levels
   always_comb begin
      result.fan_a_level = fan_a_cur_in;
      result.fan_b_level = fan_b_cur_in;
      result.peltier_a_level = pelt_a_cur_in;
      result.peltier_b_level = pelt_b_cur_in;
      result.peltier_a_drive = polar(pelt_high_ff, pelt_a_cur_in);
      result.peltier_b_drive = polar(pelt_high_ff, pelt_b_cur_in);
      result.peltier_fan_a_drive = polar(pelt_high_ff, (pelt_a_cur_in != '0) ?
                                         pslw_pkg::DUTY_FULL : pslw_pkg::DUTY_OFF);
      result.peltier_fan_b_drive = polar(pelt_high_ff, (pelt_b_cur_in != '0) ?
                                         pslw_pkg::DUTY_FULL : pslw_pkg::DUTY_OFF);
      result.command_stale = stale;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fan_a_cur_ff <= '0;
         fan_b_cur_ff <= '0;
         fan_a_goal_ff <= '0;
         fan_b_goal_ff <= '0;
         pelt_a_goal_ff <= '0;
         pelt_b_goal_ff <= '0;
         pelt_a_cur_ff <= '0;
         pelt_b_cur_ff <= '0;
         last_cmd_ff <= '0;
      end else if (req_accept) begin
         fan_a_cur_ff <= fan_a_cur_in;
         fan_b_cur_ff <= fan_b_cur_in;
         fan_a_goal_ff <= fan_a_goal_in;
         fan_b_goal_ff <= fan_b_goal_in;
         pelt_a_goal_ff <= pelt_a_goal_in;
         pelt_b_goal_ff <= pelt_b_goal_in;
         pelt_a_cur_ff <= pelt_a_cur_in;
         pelt_b_cur_ff <= pelt_b_cur_in;
         last_cmd_ff <= last_cmd_in;
      end
   end

   // Output register and skid entry control
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_pop) begin
            out_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_accept) begin
         if (!out_valid_ff || out_pop) begin
            out_valid_in = 1'b1;
            out_data_in = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in = result;
         end
      end else if (out_pop) begin
         out_valid_in = 1'b0;
      end
   end

   // Valid bits reset; payload registers do not
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

`ifndef SYNTH
   // Skid entry is only used behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // A command records its time stamp
   a_cmd_time: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_cmd) |=> (last_cmd_ff == $past(req_data.now_ms)))
      else $error("command time not recorded");

   // A stale tick clears every goal
   a_stale_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && stale) |=> (fan_a_goal_ff == '0 && fan_b_goal_ff == '0 &&
                                 pelt_a_goal_ff == '0 && pelt_b_goal_ff == '0))
      else $error("stale tick left a goal set");

   // Absent fan is held at zero after a tick
   a_fan_a_absent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && !is_cmd && !fan_a_pres_ff) |=> (fan_a_cur_ff == '0))
      else $error("absent fan A not held at zero");

   // Every accepted beat lands in the output stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> out_valid_ff)
      else $error("accepted beat lost");
`endif

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PWM slew limiter with command watchdog.
// A queue-fed driver sends tick and command beats, a monitor compares every
// result beat against an in-bench model of the fan ramps, Peltier levels,
// polarity and timeout fallback. Configuration changes happen between phases
// while the block is drained; both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int unsigned DUTY_W = pslw_pkg::DUTY_W;
   localparam int unsigned TIME_W = pslw_pkg::TIME_W;
   localparam int unsigned CSR_IDX_W = pslw_pkg::CSR_IDX_W;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   pslw_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   pslw_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIME_W-1:0] csr_wdata = '0;

   // pending input beats and the levels they are expected to produce
   pslw_pkg::req_type pending_events[$];
   pslw_pkg::rsp_type expected_levels[$];
   int mismatches = 0;
   // when set, neither side idles
   logic calm = 1'b0;

   // configuration mirror
   logic [TIME_W-1:0] cfg_ttl = pslw_pkg::TTL_RESET;
   logic [DUTY_W-1:0] cfg_step = pslw_pkg::STEP_RESET;
   logic cfg_fan_a_on = 1'b1;
   logic cfg_fan_b_on = 1'b1;
   logic cfg_pel_high = 1'b1;

   // state mirror
   logic [DUTY_W-1:0] cur_fan_a = '0, cur_fan_b = '0;
   logic [DUTY_W-1:0] goal_fan_a = '0, goal_fan_b = '0;
   logic [DUTY_W-1:0] goal_pel_a = '0, goal_pel_b = '0;
   logic [DUTY_W-1:0] cur_pel_a = '0, cur_pel_b = '0;
   logic [TIME_W-1:0] last_cmd_ms = '0;

   // stimulus time line
   logic [TIME_W-1:0] gen_now = '0;
   logic [TIME_W-1:0] gen_last_cmd = '0;

   pwm_slew_limiter_with_watchdog u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Ramp a fan level toward its goal by at most one step
   function automatic logic [DUTY_W-1:0] ramp_toward(input logic [DUTY_W-1:0] cur,
                                                     input logic [DUTY_W-1:0] goal,
                                                     input logic [DUTY_W-1:0] step);
      logic [DUTY_W:0] up;
      up = {1'b0, cur} + {1'b0, step};
      if (cur < goal) return (up > {1'b0, goal}) ? goal : up[DUTY_W-1:0];
      if (cur > goal) return ((cur - goal) < step) ? goal : cur - step;
      return cur;
   endfunction

   function automatic logic [DUTY_W-1:0] pel_polarity(input logic [DUTY_W-1:0] v);
      return cfg_pel_high ? v : pslw_pkg::DUTY_FULL - v;
   endfunction

   // Advance the mirror by one beat and return the levels it reports
   function automatic pslw_pkg::rsp_type predict_levels(input pslw_pkg::req_type ev);
      pslw_pkg::rsp_type r;
      logic [TIME_W-1:0] age;
      logic stale;
      stale = 1'b0;
      if (ev.action == pslw_pkg::ACTION_COMMAND) begin
         goal_fan_a = ev.fan_a_target;
         goal_fan_b = ev.fan_b_target;
         goal_pel_a = ev.peltier_a_target;
         goal_pel_b = ev.peltier_b_target;
         last_cmd_ms = ev.now_ms;
      end else begin
         age = ev.now_ms - last_cmd_ms;
         if (age > cfg_ttl) begin
            goal_fan_a = pslw_pkg::DUTY_OFF;
            goal_fan_b = pslw_pkg::DUTY_OFF;
            goal_pel_a = pslw_pkg::DUTY_OFF;
            goal_pel_b = pslw_pkg::DUTY_OFF;
            stale = 1'b1;
         end
         cur_fan_a = cfg_fan_a_on ? ramp_toward(cur_fan_a, goal_fan_a, cfg_step)
                                  : pslw_pkg::DUTY_OFF;
         cur_fan_b = cfg_fan_b_on ? ramp_toward(cur_fan_b, goal_fan_b, cfg_step)
                                  : pslw_pkg::DUTY_OFF;
         cur_pel_a = goal_pel_a;
         cur_pel_b = goal_pel_b;
      end
      r.fan_a_level = cur_fan_a;
      r.fan_b_level = cur_fan_b;
      r.peltier_a_level = cur_pel_a;
      r.peltier_b_level = cur_pel_b;
      r.peltier_a_drive = pel_polarity(cur_pel_a);
      r.peltier_b_drive = pel_polarity(cur_pel_b);
      r.peltier_fan_a_drive = pel_polarity(cur_pel_a != pslw_pkg::DUTY_OFF ?
                                           pslw_pkg::DUTY_FULL : pslw_pkg::DUTY_OFF);
      r.peltier_fan_b_drive = pel_polarity(cur_pel_b != pslw_pkg::DUTY_OFF ?
                                           pslw_pkg::DUTY_FULL : pslw_pkg::DUTY_OFF);
      r.command_stale = stale;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [DUTY_W-1:0] exp_v,
                                input logic [DUTY_W-1:0] act_v);
      if (act_v !== exp_v) begin
         $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   task automatic check_levels(input pslw_pkg::rsp_type act);
      pslw_pkg::rsp_type e;
      if (expected_levels.size() == 0) begin
         $display("%0t: result beat expected none got %h", $time, act);
         mismatches++;
      end else begin
         e = expected_levels.pop_front();
         compare_field("fan_a_level", e.fan_a_level, act.fan_a_level);
         compare_field("fan_b_level", e.fan_b_level, act.fan_b_level);
         compare_field("peltier_a_level", e.peltier_a_level, act.peltier_a_level);
         compare_field("peltier_b_level", e.peltier_b_level, act.peltier_b_level);
         compare_field("peltier_a_drive", e.peltier_a_drive, act.peltier_a_drive);
         compare_field("peltier_b_drive", e.peltier_b_drive, act.peltier_b_drive);
         compare_field("peltier_fan_a_drive", e.peltier_fan_a_drive,
                       act.peltier_fan_a_drive);
         compare_field("peltier_fan_b_drive", e.peltier_fan_b_drive,
                       act.peltier_fan_b_drive);
         compare_field("command_stale", DUTY_W'(e.command_stale),
                       DUTY_W'(act.command_stale));
      end
   endtask

   // Input driver: predicts each accepted beat, then offers the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expected_levels.push_back(predict_levels(req_data));
         if (pending_events.size() != 0 && (calm || $urandom_range(99) >= 37)) begin
            req_data <= pending_events.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_levels(rsp_data);
         rsp_stall <= !calm && ($urandom_range(99) < 37);
      end
   end

   task automatic write_csr(input pslw_pkg::csr_index_type idx,
                            input logic [TIME_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         pslw_pkg::CSR_COMMAND_TTL_MS: cfg_ttl = val;
         pslw_pkg::CSR_RAMP_STEP: cfg_step = val[DUTY_W-1:0];
         pslw_pkg::CSR_FAN_A_PRESENT: cfg_fan_a_on = val[0];
         pslw_pkg::CSR_FAN_B_PRESENT: cfg_fan_b_on = val[0];
         pslw_pkg::CSR_PELTIER_ACTIVE_HIGH: cfg_pel_high = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [TIME_W-1:0] ttl, input logic [DUTY_W-1:0] step,
                             input logic fan_a_on, input logic fan_b_on,
                             input logic pel_high);
      write_csr(pslw_pkg::CSR_COMMAND_TTL_MS, ttl);
      write_csr(pslw_pkg::CSR_RAMP_STEP, TIME_W'(step));
      write_csr(pslw_pkg::CSR_FAN_A_PRESENT, TIME_W'(fan_a_on));
      write_csr(pslw_pkg::CSR_FAN_B_PRESENT, TIME_W'(fan_b_on));
      write_csr(pslw_pkg::CSR_PELTIER_ACTIVE_HIGH, TIME_W'(pel_high));
   endtask

   // Wait until every queued beat went in and every result came out
   task automatic drain();
      do @(negedge clock);
      while (pending_events.size() != 0 || req_valid || expected_levels.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic push_event(input pslw_pkg::action_type act,
                             input logic [TIME_W-1:0] now,
                             input logic [DUTY_W-1:0] fa, input logic [DUTY_W-1:0] fb,
                             input logic [DUTY_W-1:0] pa, input logic [DUTY_W-1:0] pb);
      pslw_pkg::req_type ev;
      ev.action = act;
      ev.now_ms = now;
      ev.fan_a_target = fa;
      ev.fan_b_target = fb;
      ev.peltier_a_target = pa;
      ev.peltier_b_target = pb;
      pending_events.push_back(ev);
   endtask

   // Mostly an ordered time line of commands and ticks, some near the timeout
   // edge, plus out-of-order time stamps as noise
   task automatic queue_random(input int count);
      int unsigned r;
      pslw_pkg::action_type act;
      logic [TIME_W-1:0] now;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         act = pslw_pkg::ACTION_TICK;
         if (r < 25) begin
            gen_now = gen_now + $urandom_range(50);
            gen_last_cmd = gen_now;
            act = pslw_pkg::ACTION_COMMAND;
            now = gen_now;
         end else if (r < 35) begin
            now = $urandom;
         end else if (r < 47) begin
            gen_now = gen_last_cmd + cfg_ttl + $urandom_range(2) - 1;
            now = gen_now;
         end else begin
            gen_now = gen_now + $urandom_range(40);
            now = gen_now;
         end
         push_event(act, now, DUTY_W'($urandom_range(255)), DUTY_W'($urandom_range(255)),
                    DUTY_W'($urandom_range(255)), DUTY_W'($urandom_range(255)));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: default settings, ramps, timeout edge, time wrap
      push_event(pslw_pkg::ACTION_TICK, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00);
      push_event(pslw_pkg::ACTION_COMMAND, 32'd100, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_event(pslw_pkg::ACTION_TICK, 32'd101, 8'h00, 8'h00, 8'h00, 8'h00);
      push_event(pslw_pkg::ACTION_TICK, 32'd102, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_event(pslw_pkg::ACTION_COMMAND, 32'd200, 8'h06, 8'hFF, 8'h00, 8'h80);
      push_event(pslw_pkg::ACTION_TICK, 32'd200, 8'h00, 8'h00, 8'h00, 8'h00);
      // age equal to the timeout is still fresh, one more is stale
      push_event(pslw_pkg::ACTION_TICK, 32'd10200, 8'h00, 8'h00, 8'h00, 8'h00);
      push_event(pslw_pkg::ACTION_TICK, 32'd10201, 8'h00, 8'h00, 8'h00, 8'h00);
      push_event(pslw_pkg::ACTION_TICK, 32'd10202, 8'h00, 8'h00, 8'h00, 8'h00);
      // command at the top of the time range, ticks after the wrap
      push_event(pslw_pkg::ACTION_COMMAND, 32'hFFFF_FFFF, 8'h00, 8'h00, 8'hFF, 8'h01);
      push_event(pslw_pkg::ACTION_TICK, 32'd5, 8'h00, 8'h00, 8'h00, 8'h00);
      push_event(pslw_pkg::ACTION_TICK, 32'd10000, 8'h00, 8'h00, 8'h00, 8'h00);
      push_event(pslw_pkg::ACTION_COMMAND, 32'h8000_0000, 8'h55, 8'hAA, 8'h7F, 8'hFE);
      push_event(pslw_pkg::ACTION_TICK, 32'h8000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      push_event(pslw_pkg::ACTION_TICK, 32'h8000_2710, 8'h00, 8'h00, 8'h00, 8'h00);
      drain();

      // zero timeout, largest step, fan A absent, inverted Peltier drive
      set_config(32'd0, 8'd255, 1'b0, 1'b1, 1'b0);
      gen_now = $urandom;
      gen_last_cmd = gen_now;
      queue_random(315);
      drain();

      // timeout never expires, unit step, fan B absent; no idling here
      calm = 1'b1;
      set_config(32'hFFFF_FFFF, 8'd1, 1'b1, 1'b0, 1'b1);
      queue_random(315);
      drain();
      calm = 1'b0;

      // zero step freezes present fans; sender holds off halfway
      set_config(32'd50, 8'd0, 1'b1, 1'b1, 1'b0);
      queue_random(150);
      drain();
      queue_random(165);
      drain();

      set_config($urandom_range(2000, 20), DUTY_W'($urandom_range(255, 1)),
                 1'b1, 1'b1, 1'b1);
      gen_now = 32'hFFFF_FF00;
      gen_last_cmd = gen_now;
      queue_random(315);
      drain();

      set_config($urandom, DUTY_W'($urandom_range(16, 2)), 1'($urandom_range(1)),
                 1'($urandom_range(1)), 1'($urandom_range(1)));
      queue_random(315);
      drain();

      // back to the reset settings
      set_config(pslw_pkg::TTL_RESET, pslw_pkg::STEP_RESET, 1'b1, 1'b1, 1'b1);
      queue_random(315);
      drain();

      repeat (10) @(posedge clock);
      if (mismatches == 0 && expected_levels.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   // Watchdog on the whole run
   initial begin
      #1_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/pslw_pkg.sv
hdl/pwm_slew_limiter_with_watchdog.sv
sim/tb.sv
